// ===== sv/assert_macros.svh =====
// Assertion macros shared by the sliding window blocks.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define SWMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset
`define SWMP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== sv/swmp_pkg.sv =====
// Shared types and constants of the sliding window mean and percentile core.
// No dependencies; the cell, divider, core and result interface import it.
package swmp_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERCENTILE   = 2'd2;

    localparam int COLS_W = 7;
    localparam int HALF_W = 4;
    localparam int FRAC_W = 16;
    localparam logic [COLS_W-1:0] COLS_RESET = 7'd30;
    localparam logic [HALF_W-1:0] HALF_RESET = 4'd5;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 16'd58982;

    // Result word fields
    localparam int ROW_IDX_W = 12;
    localparam int RESULT_W  = 24;
    localparam int COUNT_W   = 11;

    // Row counters (twice the largest half width plus one fits)
    localparam int ROWCNT_W = 6;

    // Rank selection groups
    localparam int GRP_W = 6;
    localparam int GRP   = 64;

    // Broadcast command to the sorted cell chain
    typedef struct packed {
        logic clear;
        logic ins;
        logic rem;
    } chain_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_RANK,
        ST_SEL_GRP,
        ST_SEL_FIN,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== sv/swmp_if.sv =====
// Handshake channels of the sliding window core: sample words in, result words out.
// Depends on swmp_pkg for the field widths.
interface swmp_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_valid;
    logic                          series_start;

    modport source (output valid, sample, sample_valid, series_start, input ready);
    modport sink   (input valid, sample, sample_valid, series_start, output ready);
endinterface

interface swmp_out_if import swmp_pkg::*; ;
    logic                       valid;
    logic                       ready;
    logic [ROW_IDX_W-1:0]       center_row;
    logic signed [RESULT_W-1:0] mean_value;
    logic signed [RESULT_W-1:0] threshold_value;
    logic [COUNT_W-1:0]         valid_count;
    logic                       no_data;

    modport source (output valid, center_row, mean_value, threshold_value, valid_count,
                    no_data, input ready);
    modport sink   (input valid, center_row, mean_value, threshold_value, valid_count,
                    no_data, output ready);
endinterface

// ===== sv/swmp_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
module swmp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1984
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/swmp_cell.sv =====
// One cell of the sorted chain: holds one sample and an occupied flag.
// Depends on swmp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swmp_cell import swmp_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  chain_op_t                     op,
    input  logic signed [SAMPLE_BITS-1:0] key,
    input  logic signed [SAMPLE_BITS-1:0] left_val,
    input  logic                          left_occ,
    input  logic                          left_stay,
    input  logic signed [SAMPLE_BITS-1:0] right_val,
    input  logic                          right_occ,
    output logic signed [SAMPLE_BITS-1:0] val,
    output logic                          occ,
    output logic                          stay
);

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic                          occ_reg, occ_next;
    logic                          at_or_after;

    // Cells not above the key keep their place on insert
    assign stay        = occ_reg && (val_reg <= key);
    assign at_or_after = occ_reg && (val_reg >= key);

    // Clear empties the cell; insert shifts right of the key position, remove shifts left from it
    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        priority if (op.clear)
        begin
            occ_next = 1'b0;
        end
        else if (op.ins && !stay)
        begin
            if (left_stay)
            begin
                val_next = key;
                occ_next = 1'b1;
            end
            else
            begin
                val_next = left_val;
                occ_next = left_occ;
            end
        end
        else if (op.rem && at_or_after)
        begin
            val_next = right_val;
            occ_next = right_occ;
        end
        else
        begin
            val_next = val_reg;
            occ_next = occ_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign occ = occ_reg;

    `SWMP_ASSERT(a_cell_sorted, (occ_reg && right_occ) |-> (val_reg <= right_val), "chain out of order")
    `SWMP_ASSERT_NEVER(a_cell_packed, !occ_reg && right_occ, "hole in sorted chain")

endmodule

// ===== sv/swmp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on swmp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swmp_div import swmp_pkg::*; #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // Trial subtraction of the shifted remainder
    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Shift in one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

    `SWMP_ASSERT_NEVER(a_div_restart, start && busy_reg, "divider started while busy")

endmodule

// ===== sv/sliding_window_mean_percentile_core.sv =====
// Sliding window mean and interpolated percentile over a row-structured sample stream.
// Depends on swmp_pkg, swmp_if, swmp_ram, swmp_cell, swmp_div, assert_macros.svh.
//
// Samples arrive row by row; the core keeps the last 2*half_width+1 rows in a delay
// RAM and the valid ones in a chain of sorted cells, one cell per window slot. Each
// sample passes three steps: one reads the oldest slot from the delay RAM, one drops
// it from the chain and the running sum, and one inserts the new sample and writes
// the RAM. The sample that closes a row in a full window also produces a result word:
// the rank is picked from the chain through a two-level registered select while the
// mean goes through a bit-serial divider of SAMPLE_BITS+clog2(window cells+1)+9 steps
// (36 at default parameters), which sets the length of that sample; an empty window
// skips the select and the divider. A result word waits in an output register while
// new samples are taken. Stale RAM entries are masked by a row fill count, so there
// is no clearing pass after reset. Writing the column count or half width clears the
// window, like a series start.
`include "assert_macros.svh"

module sliding_window_mean_percentile_core import swmp_pkg::*; #(
    parameter int MAX_COLUMNS    = 64,
    parameter int MAX_HALF_WIDTH = 15,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    swmp_in_if.sink                samples,
    swmp_out_if.source             results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SB      = SAMPLE_BITS;
    localparam int MAX_ROWS = 2 * MAX_HALF_WIDTH + 1;
    localparam int CAP     = MAX_COLUMNS * MAX_ROWS;
    localparam int CNT_W   = $clog2(CAP + 1);
    localparam int ADDR_W  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int IDX_W   = ADDR_W + ROWCNT_W + 1;
    localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int SUM_W   = SB + CNT_W;
    localparam int DIV_W   = SUM_W + 9;
    localparam int K_W     = CNT_W + FRAC_W;
    localparam int Q_W     = SB + 18;
    localparam int MAG_A   = (DIV_W > Q_W + 1) ? DIV_W : Q_W + 1;
    localparam int MAG_W   = (MAG_A > RESULT_W + 1) ? MAG_A : RESULT_W + 1;
    localparam int NGRP    = (CAP + GRP - 1) / GRP;
    localparam int NPAD    = NGRP * GRP;
    localparam int GI_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int LO_X_W  = CNT_W + GRP_W + GI_W;

    // Configuration and window bookkeeping
    logic [COLS_W-1:0]       col_count_reg;
    logic [HALF_W-1:0]       half_reg;
    logic [FRAC_W-1:0]       frac_reg;
    logic [COL_W-1:0]        col_pos_reg;
    logic [ROWCNT_W-1:0]     ring_reg;
    logic [ROWCNT_W-1:0]     filled_reg;
    logic [ROW_IDX_W-1:0]    rows_seen_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    state_t                  state_reg, state_next;

    // Payload holding registers
    logic signed [SB-1:0]       smp_reg;
    logic                       smpv_reg;
    logic [ROW_IDX_W-1:0]       center_reg;
    logic [K_W-1:0]             k_reg;
    logic signed [SB-1:0]       grp_lo_reg [NGRP];
    logic signed [SB-1:0]       grp_hi_reg [NGRP];
    logic signed [SB-1:0]       v_lo_reg;
    logic signed [SB-1:0]       v_hi_reg;
    logic signed [Q_W-1:0]      pa_reg;
    logic signed [Q_W-1:0]      pb_reg;
    logic [RESULT_W-1:0]        thr_reg;

    // Output register
    logic                 out_valid_reg;
    logic [ROW_IDX_W-1:0] out_row_reg;
    logic [RESULT_W-1:0]  out_mean_reg;
    logic [RESULT_W-1:0]  out_thr_reg;
    logic [COUNT_W-1:0]   out_cnt_reg;
    logic                 out_nodata_reg;

    // Control
    logic                 in_acc;
    logic                 cfg_clear;
    logic                 clear_now;
    logic                 ready;
    logic                 ram_we;
    logic                 div_start;
    logic                 div_busy;
    logic                 out_load;
    chain_op_t            op;
    logic signed [SB-1:0] key;

    logic [8:0]          eff_cols;
    logic [4:0]          eff_h;
    logic [ROWCNT_W-1:0] win_rows;
    logic [ROWCNT_W-1:0] filled_inc;
    logic                row_end;
    logic                win_done;
    logic                full;
    logic [IDX_W-1:0]    idx_wide;
    logic [ADDR_W-1:0]   cur_idx;
    logic [SB:0]         ram_rdata;
    logic                old_valid;
    logic signed [SB-1:0] old_smp;

    logic [CNT_W-1:0]     lo;
    logic [CNT_W-1:0]     hi;
    logic [LO_X_W-1:0]    lo_x;
    logic [LO_X_W-1:0]    hi_x;
    logic [GRP_W-1:0]     lo_off;
    logic [GRP_W-1:0]     hi_off;
    logic [GI_W-1:0]      lo_grp;
    logic [GI_W-1:0]      hi_grp;
    logic [FRAC_W-1:0]    t;
    logic [FRAC_W:0]      wt_lo;
    logic signed [Q_W:0]  q_sum;
    logic [Q_W:0]         q_mag;
    logic [Q_W:0]         q_rnd;
    logic [SUM_W-1:0]     sum_mag;
    logic [DIV_W-1:0]     div_num;
    logic [DIV_W-1:0]     div_quot;

    logic signed [SB-1:0] cell_val [CAP];
    logic                 cell_occ [CAP];
    logic                 cell_stay [CAP];
    logic signed [SB-1:0] pad_val [NPAD];

    function automatic logic [RESULT_W-1:0] sat24(input logic neg,
                                                  input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0]    lim;
        logic [RESULT_W-1:0] res;
        lim = neg ? MAG_W'(24'h800000) : MAG_W'(24'h7FFFFF);
        if (mag > lim)
        begin
            res = neg ? 24'h800000 : 24'h7FFFFF;
        end
        else
        begin
            res = neg ? (~mag[RESULT_W-1:0] + 24'd1) : mag[RESULT_W-1:0];
        end
        return res;
    endfunction

    // Handshake and clear requests
    assign in_acc        = samples.valid && ready;
    assign samples.ready = ready;
    assign cfg_clear     = cfg_we && (cfg_index == REG_COLUMN_COUNT ||
                                      cfg_index == REG_HALF_WIDTH);
    assign clear_now     = cfg_clear || (in_acc && samples.series_start);

    // Effective geometry
    always_comb
    begin
        if (col_count_reg == '0)
        begin
            eff_cols = 9'd1;
        end
        else if (9'(col_count_reg) > 9'(MAX_COLUMNS))
        begin
            eff_cols = 9'(MAX_COLUMNS);
        end
        else
        begin
            eff_cols = 9'(col_count_reg);
        end
        eff_h = (5'(half_reg) > 5'(MAX_HALF_WIDTH)) ? 5'(MAX_HALF_WIDTH) : 5'(half_reg);
    end

    assign win_rows   = {eff_h, 1'b1};
    assign full       = filled_reg == win_rows;
    assign filled_inc = full ? filled_reg : filled_reg + ROWCNT_W'(1);
    assign row_end    = (9'(col_pos_reg) + 9'd1) >= eff_cols;
    assign win_done   = filled_inc == win_rows;
    assign idx_wide   = IDX_W'(ring_reg) * IDX_W'(MAX_COLUMNS) + IDX_W'(col_pos_reg);
    assign cur_idx    = idx_wide[ADDR_W-1:0];

    // Delay line of raw samples with their valid bit
    swmp_ram #(
        .WIDTH (SB + 1),
        .DEPTH (CAP)
    ) u_delay (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_idx),
        .wdata ({smpv_reg, smpv_reg ? smp_reg : SB'(0)}),
        .raddr (cur_idx),
        .rdata (ram_rdata)
    );

    assign old_valid = full && ram_rdata[SB];
    assign old_smp   = ram_rdata[SB-1:0];

    // Sorted chain of cells
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        swmp_cell #(
            .SAMPLE_BITS (SB)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .key       (key),
            .left_val  ((i == 0) ? SB'(0) : cell_val[(i == 0) ? 0 : i - 1]),
            .left_occ  ((i == 0) ? 1'b0 : cell_occ[(i == 0) ? 0 : i - 1]),
            .left_stay ((i == 0) ? 1'b1 : cell_stay[(i == 0) ? 0 : i - 1]),
            .right_val ((i == CAP - 1) ? SB'(0) : cell_val[(i == CAP - 1) ? i : i + 1]),
            .right_occ ((i == CAP - 1) ? 1'b0 : cell_occ[(i == CAP - 1) ? i : i + 1]),
            .val       (cell_val[i]),
            .occ       (cell_occ[i]),
            .stay      (cell_stay[i])
        );
    end

    for (genvar i = 0; i < NPAD; i++)
    begin : g_pad
        if (i < CAP)
        begin : g_real
            assign pad_val[i] = cell_val[i];
        end
        else
        begin : g_fill
            assign pad_val[i] = '0;
        end
    end

    // Rank positions of the two interpolation points
    assign lo     = k_reg[FRAC_W +: CNT_W];
    assign hi     = (lo == cnt_reg - CNT_W'(1)) ? lo : lo + CNT_W'(1);
    assign t      = k_reg[FRAC_W-1:0];
    assign wt_lo  = 17'h10000 - {1'b0, t};
    assign lo_x   = LO_X_W'(lo);
    assign hi_x   = LO_X_W'(hi);
    assign lo_off = lo_x[GRP_W-1:0];
    assign hi_off = hi_x[GRP_W-1:0];
    assign lo_grp = lo_x[GRP_W +: GI_W];
    assign hi_grp = hi_x[GRP_W +: GI_W];

    // First select level: a low and a high pick per group of cells
    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        logic signed [SB-1:0] seg [GRP];
        for (genvar j = 0; j < GRP; j++)
        begin : g_seg
            assign seg[j] = pad_val[g * GRP + j];
        end
        always_ff @(posedge clk)
        begin
            if (state_reg == ST_SEL_GRP)
            begin
                grp_lo_reg[g] <= seg[lo_off];
                grp_hi_reg[g] <= seg[hi_off];
            end
        end
    end

    // Mean divider: |sum| * 256 + n/2 over n
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_num = {1'b0, sum_mag, 8'b0} + DIV_W'(cnt_reg >> 1);

    swmp_div #(
        .NUM_W (DIV_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cnt_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Threshold rounding, ties away from zero
    assign q_sum = (Q_W + 1)'(pa_reg) + (Q_W + 1)'(pb_reg);
    assign q_mag = q_sum[Q_W] ? (Q_W + 1)'(-q_sum) : (Q_W + 1)'(q_sum);
    assign q_rnd = (q_mag + (Q_W + 1)'(128)) >> 8;

    // Next state and chain commands
    always_comb
    begin
        state_next = state_reg;
        op         = '0;
        op.clear   = clear_now;
        key        = smp_reg;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        ready      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (samples.valid)
                begin
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE:
            begin
                key        = old_smp;
                op.rem     = old_valid;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                op.ins     = smpv_reg;
                ram_we     = 1'b1;
                state_next = (row_end && win_done) ? ST_RANK : ST_IDLE;
            end
            ST_RANK:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_SEL_GRP;
                end
            end
            ST_SEL_GRP: state_next = ST_SEL_FIN;
            ST_SEL_FIN: state_next = ST_MUL;
            ST_MUL:     state_next = ST_SUM;
            ST_SUM:     state_next = ST_DIV;
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration and window counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= COLS_RESET;
            half_reg      <= HALF_RESET;
            frac_reg      <= FRAC_RESET;
            col_pos_reg   <= '0;
            ring_reg      <= '0;
            filled_reg    <= '0;
            rows_seen_reg <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_COLUMN_COUNT)
                begin
                    col_count_reg <= cfg_data[COLS_W-1:0];
                end
                if (cfg_index == REG_HALF_WIDTH)
                begin
                    half_reg <= cfg_data[HALF_W-1:0];
                end
                if (cfg_index == REG_PERCENTILE)
                begin
                    frac_reg <= cfg_data[FRAC_W-1:0];
                end
            end
            if (clear_now)
            begin
                col_pos_reg   <= '0;
                ring_reg      <= '0;
                filled_reg    <= '0;
                rows_seen_reg <= '0;
                cnt_reg       <= '0;
                sum_reg       <= '0;
            end
            else if (state_reg == ST_REMOVE && old_valid)
            begin
                sum_reg <= sum_reg - SUM_W'(old_smp);
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            else if (state_reg == ST_INSERT)
            begin
                if (smpv_reg)
                begin
                    sum_reg <= sum_reg + SUM_W'(smp_reg);
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (row_end)
                begin
                    col_pos_reg   <= '0;
                    ring_reg      <= (ring_reg + ROWCNT_W'(1) == win_rows) ? '0
                                     : ring_reg + ROWCNT_W'(1);
                    rows_seen_reg <= rows_seen_reg + ROW_IDX_W'(1);
                    filled_reg    <= filled_inc;
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + COL_W'(1);
                end
            end
        end
    end

    // Sample capture and result datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            smp_reg  <= samples.sample;
            smpv_reg <= samples.sample_valid;
        end
        if (state_reg == ST_INSERT)
        begin
            center_reg <= rows_seen_reg - ROW_IDX_W'(eff_h);
        end
        if (state_reg == ST_RANK)
        begin
            k_reg <= K_W'(cnt_reg - CNT_W'(1)) * K_W'(frac_reg);
        end
        if (state_reg == ST_SEL_FIN)
        begin
            v_lo_reg <= grp_lo_reg[lo_grp];
            v_hi_reg <= grp_hi_reg[hi_grp];
        end
        if (state_reg == ST_MUL)
        begin
            pa_reg <= Q_W'(v_lo_reg) * Q_W'($signed({1'b0, wt_lo}));
            pb_reg <= Q_W'(v_hi_reg) * Q_W'($signed({2'b0, t}));
        end
        if (state_reg == ST_SUM)
        begin
            thr_reg <= sat24(q_sum[Q_W], MAG_W'(q_rnd));
        end
    end

    // Output register: hold until taken, reload from the result state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg    <= center_reg;
            out_nodata_reg <= cnt_reg == '0;
            out_cnt_reg    <= COUNT_W'(cnt_reg);
            if (cnt_reg == '0)
            begin
                out_mean_reg <= '0;
                out_thr_reg  <= '0;
            end
            else
            begin
                out_mean_reg <= sat24(sum_reg[SUM_W-1], MAG_W'(div_quot));
                out_thr_reg  <= thr_reg;
            end
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.center_row      = out_row_reg;
    assign results.mean_value      = out_mean_reg;
    assign results.threshold_value = out_thr_reg;
    assign results.valid_count     = out_cnt_reg;
    assign results.no_data         = out_nodata_reg;

    `SWMP_ASSERT(a_cnt_cap, cnt_reg <= CNT_W'(CAP), "valid count beyond window capacity")
    `SWMP_ASSERT_NEVER(a_div_idle, div_busy && state_reg == ST_IDLE, "divider busy while idle")
    `SWMP_ASSERT(a_out_src, $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT, "stray result word")

endmodule
